// File: rtl/crmp_pkg.sv
// Package for the clamped recurrent matrix power block: sizes, codes,
// payload structs, sequencer states and the shared double-precision unit's
// request and response types. No dependencies.
package crmp_pkg;

  localparam int DIM       = 5;
  localparam int MAX_STEPS = 128;

  localparam int IDX_W     = $clog2(DIM);
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int CFG_W     = 8;
  localparam int MAT_DEPTH = DIM * DIM;
  localparam int MAT_AW    = $clog2(MAT_DEPTH);
  // block 0 holds the start vector, block k holds chain vector s_k
  localparam int VEC_DEPTH = (MAX_STEPS + 1) * DIM;
  localparam int VEC_AW    = $clog2(VEC_DEPTH);

  localparam logic [CFG_W-1:0] STEP_COUNT_RST = CFG_W'(100);

  localparam logic [1:0] FUNC_MAT = 2'd0;
  localparam logic [1:0] FUNC_VEC = 2'd1;
  localparam logic [1:0] FUNC_RUN = 2'd2;

  localparam logic [63:0] DBL_ZERO    = 64'h0000_0000_0000_0000;
  localparam logic [63:0] CLAMP_HIGH  = 64'h4034_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

  // working mantissa: bit MW-1 carry, bit MW-2 hidden one
  localparam int MW = 108;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  element_index;
    logic [63:0] element_value;
    logic        last;
  } out_item_t;

  typedef enum logic {
    FPU_MUL,
    FPU_ADD
  } fpu_op_e;

  typedef struct packed {
    logic        start;
    fpu_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL,
    FS_ALIGN,
    FS_ADD,
    FS_NORM,
    FS_DENORM,
    FS_ROUND
  } fpu_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_MULW,
    S_ADDW,
    S_ARD0,
    S_ALD,
    S_ARD,
    S_AADD,
    S_AADDW,
    S_OUT
  } seq_state_e;

endpackage

// File: rtl/clamped_recurrent_matrix_power.sv
// Top level of the clamped recurrent matrix power block: sequencer, matrix
// and vector memories, clamp. Depends on crmp_pkg and crmp_fpu.
//
//   channel | signals                         | direction
//   in      | in_valid_i, in_stall_o, in_data_i | item in (load or run)
//   out     | out_valid_o, out_stall_i, out_data_o | one element per transaction
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i | step_count write
//
// Every step of a run, chain product or clamped sum add, goes through the
// one shared double multiply/add unit.
// The input stalls until the last element has been taken. Reset clears the
// sequencer and sets step_count to 100; memories hold no reset.
module clamped_recurrent_matrix_power (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  crmp_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output crmp_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [crmp_pkg::CFG_W-1:0]      cfg_data_i
);
  import crmp_pkg::*;

  logic [63:0] mat_mem [MAT_DEPTH];
  logic [63:0] vec_mem [VEC_DEPTH];

  seq_state_e       st_q, st_d;
  logic [CFG_W-1:0] step_count_q;
  logic [STEP_W-1:0] p_q, p_d;
  logic [STEP_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [63:0]      acc_q, acc_d;
  logic [63:0]      r_q, r_d;
  logic [63:0]      mat_rd_q, vec_rd_q;

  logic              in_acc;
  logic              mat_we, vec_we;
  logic [MAT_AW-1:0] mat_waddr, mat_raddr;
  logic [VEC_AW-1:0] vec_waddr, vec_raddr;
  logic [63:0]       vec_wdata;
  fpu_req_t          fpu_req;
  fpu_rsp_t          fpu_rsp;

  function automatic logic [63:0] clamp(input logic [63:0] s);
    logic nan;
    nan = (&s[62:52]) && (|s[51:0]);
    if (!nan && s[63] && (|s[62:0])) begin
      clamp = DBL_ZERO;
    end else if (!nan && !s[63] && (s[62:0] > CLAMP_HIGH[62:0])) begin
      clamp = CLAMP_HIGH;
    end else begin
      clamp = s;
    end
  endfunction

  crmp_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .rsp_o  (fpu_rsp)
  );

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (st_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign mat_raddr = MAT_AW'(int'(i_q) * DIM + int'(j_q));
  assign mat_waddr = MAT_AW'(int'(in_data_i.row) * DIM + int'(in_data_i.col));
  assign mat_we    = in_acc && (in_data_i.func == FUNC_MAT)
                     && (int'(in_data_i.row) < DIM) && (int'(in_data_i.col) < DIM);

  always_comb begin
    vec_raddr = VEC_AW'(int'(k_q) * DIM + int'(i_q));
    unique case (st_q)
      S_RD:    vec_raddr = VEC_AW'((int'(k_q) - 1) * DIM + int'(j_q));
      S_ARD0:  vec_raddr = VEC_AW'(int'(p_q) * DIM + int'(i_q));
      default: vec_raddr = VEC_AW'(int'(k_q) * DIM + int'(i_q));
    endcase
    if (st_q == S_IDLE) begin
      vec_waddr = VEC_AW'(in_data_i.row);
      vec_wdata = in_data_i.value;
      vec_we    = in_acc && (in_data_i.func == FUNC_VEC) && (int'(in_data_i.row) < DIM);
    end else begin
      vec_waddr = VEC_AW'(int'(k_q) * DIM + int'(i_q));
      vec_wdata = fpu_rsp.res;
      vec_we    = (st_q == S_ADDW) && fpu_rsp.done && (int'(j_q) == DIM - 1);
    end
  end

  always_comb begin
    st_d  = st_q;
    p_d   = p_q;
    k_d   = k_q;
    i_d   = i_q;
    j_d   = j_q;
    acc_d = acc_q;
    r_d   = r_q;
    fpu_req.start = 1'b0;
    fpu_req.op    = FPU_ADD;
    fpu_req.a     = acc_q;
    fpu_req.b     = fpu_rsp.res;
    unique case (st_q)
      S_IDLE: begin
        if (in_acc && (in_data_i.func == FUNC_RUN)) begin
          if (int'(step_count_q) > MAX_STEPS) begin
            p_d = STEP_W'(MAX_STEPS);
          end else begin
            p_d = STEP_W'(step_count_q);
          end
          i_d   = '0;
          j_d   = '0;
          k_d   = STEP_W'(1);
          acc_d = DBL_ZERO;
          st_d  = (step_count_q == '0) ? S_ARD0 : S_RD;
        end
      end
      S_RD: st_d = S_MUL;
      S_MUL: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = FPU_MUL;
        fpu_req.a     = mat_rd_q;
        fpu_req.b     = vec_rd_q;
        st_d          = S_MULW;
      end
      S_MULW: begin
        if (fpu_rsp.done) begin
          fpu_req.start = 1'b1;
          st_d          = S_ADDW;
        end
      end
      S_ADDW: begin
        if (fpu_rsp.done) begin
          acc_d = fpu_rsp.res;
          st_d  = S_RD;
          if (int'(j_q) == DIM - 1) begin
            acc_d = DBL_ZERO;
            j_d   = '0;
            if (int'(i_q) == DIM - 1) begin
              i_d = '0;
              if (k_q == p_q) begin
                st_d = S_ARD0;
              end else begin
                k_d = k_q + STEP_W'(1);
              end
            end else begin
              i_d = i_q + IDX_W'(1);
            end
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end
      end
      S_ARD0: st_d = S_ALD;
      S_ALD: begin
        r_d = vec_rd_q;
        k_d = p_q;
        st_d = (p_q == '0) ? S_OUT : S_ARD;
      end
      S_ARD: st_d = S_AADD;
      S_AADD: begin
        fpu_req.start = 1'b1;
        fpu_req.a     = r_q;
        fpu_req.b     = vec_rd_q;
        st_d          = S_AADDW;
      end
      S_AADDW: begin
        if (fpu_rsp.done) begin
          r_d = clamp(fpu_rsp.res);
          if (k_q == STEP_W'(1)) begin
            st_d = S_OUT;
          end else begin
            k_d  = k_q - STEP_W'(1);
            st_d = S_ARD;
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (int'(i_q) == DIM - 1) begin
            st_d = S_IDLE;
          end else begin
            i_d  = i_q + IDX_W'(1);
            st_d = S_ARD0;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      step_count_q <= STEP_COUNT_RST;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) begin
        step_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    k_q   <= k_d;
    i_q   <= i_d;
    j_q   <= j_d;
    acc_q <= acc_d;
    r_q   <= r_d;
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= in_data_i.value;
    end
    mat_rd_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= vec_wdata;
    end
    vec_rd_q <= vec_mem[vec_raddr];
  end

  assign out_valid_o              = (st_q == S_OUT);
  assign out_data_o.element_index = 3'(i_q);
  assign out_data_o.element_value = r_q;
  assign out_data_o.last          = (int'(i_q) == DIM - 1);

endmodule

// File: rtl/crmp_fpu.sv
// Shared multi-cycle IEEE double multiply / add unit, round to nearest even.
// Depends on crmp_pkg.
module crmp_fpu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crmp_pkg::fpu_req_t req_i,
  output crmp_pkg::fpu_rsp_t rsp_o
);
  import crmp_pkg::*;

  fpu_state_e         st_q, st_d;
  logic               sgn_q, sgn_d;
  logic signed [13:0] exp_q, exp_d;
  logic [MW-1:0]      m_q, m_d;
  logic [MW-1:0]      sm_q, sm_d;
  logic               stk_q, stk_d;
  logic               sub_q, sub_d;
  logic [10:0]        dif_q, dif_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [52:0]        ma_q, ma_d;
  logic [52:0]        mb_q, mb_d;
  logic [63:0]        res_q, res_d;
  logic               done_q, done_d;

  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [10:0] a_e, b_e;
  logic [52:0] a_m, b_m;
  logic        spec_hit;
  logic [63:0] spec_res;
  logic [26:0] a_part, b_part;
  logic [53:0] pp;
  logic [6:0]  pp_sh;
  logic [MW-1:0] sum, ones;
  logic [13:0] amt;
  logic [52:0] rnd;
  logic        rnd_inc;
  logic [53:0] rnd2;
  logic signed [13:0] exp_r;

  always_comb begin
    sa     = req_i.a[63];
    sb     = req_i.b[63];
    a_nan  = (&req_i.a[62:52]) && (|req_i.a[51:0]);
    b_nan  = (&req_i.b[62:52]) && (|req_i.b[51:0]);
    a_inf  = (&req_i.a[62:52]) && !(|req_i.a[51:0]);
    b_inf  = (&req_i.b[62:52]) && !(|req_i.b[51:0]);
    a_zero = !(|req_i.a[62:0]);
    b_zero = !(|req_i.b[62:0]);
    a_e    = (req_i.a[62:52] == 11'd0) ? 11'd1 : req_i.a[62:52];
    b_e    = (req_i.b[62:52] == 11'd0) ? 11'd1 : req_i.b[62:52];
    a_m    = {|req_i.a[62:52], req_i.a[51:0]};
    b_m    = {|req_i.b[62:52], req_i.b[51:0]};
    spec_hit = 1'b1;
    spec_res = DEFAULT_NAN;
    if (a_nan) begin
      spec_res = req_i.a | QUIET_BIT;
    end else if (b_nan) begin
      spec_res = req_i.b | QUIET_BIT;
    end else if (req_i.op == FPU_MUL) begin
      if ((a_inf && b_zero) || (b_inf && a_zero)) begin
        spec_res = DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
        spec_res = {sa ^ sb, 11'h7FF, 52'd0};
      end else begin
        spec_hit = 1'b0;
      end
    end else begin
      if (a_inf && b_inf && (sa != sb)) begin
        spec_res = DEFAULT_NAN;
      end else if (a_inf) begin
        spec_res = req_i.a;
      end else if (b_inf) begin
        spec_res = req_i.b;
      end else begin
        spec_hit = 1'b0;
      end
    end
  end

  always_comb begin
    a_part = cnt_q[0] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
    b_part = cnt_q[1] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
    pp     = a_part * b_part;
    pp_sh  = 7'd2 + (cnt_q[0] ? 7'd27 : 7'd0) + (cnt_q[1] ? 7'd27 : 7'd0);
    ones   = '1;
    sum    = sub_q ? (m_q - sm_q) : (m_q + sm_q);
    amt    = 14'(14'sd1 - exp_q);
    rnd    = m_q[MW-2:MW-54];
    rnd_inc = m_q[MW-55] && ((|m_q[MW-56:0]) || stk_q || rnd[0]);
    rnd2   = {1'b0, rnd} + {53'd0, rnd_inc};
    exp_r  = rnd2[53] ? (exp_q + 14'sd1) : exp_q;
  end

  always_comb begin
    st_d   = st_q;
    sgn_d  = sgn_q;
    exp_d  = exp_q;
    m_d    = m_q;
    sm_d   = sm_q;
    stk_d  = stk_q;
    sub_d  = sub_q;
    dif_d  = dif_q;
    cnt_d  = cnt_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    res_d  = res_q;
    done_d = 1'b0;
    unique case (st_q)
      FS_IDLE: begin
        if (req_i.start) begin
          stk_d = 1'b0;
          if (spec_hit) begin
            res_d  = spec_res;
            done_d = 1'b1;
          end else if (req_i.op == FPU_MUL) begin
            sgn_d = sa ^ sb;
            exp_d = $signed({3'd0, a_e}) + $signed({3'd0, b_e}) - 14'sd1023;
            ma_d  = a_m;
            mb_d  = b_m;
            m_d   = '0;
            cnt_d = 2'd0;
            st_d  = FS_MUL;
          end else begin
            sub_d = sa ^ sb;
            if ({a_e, a_m} >= {b_e, b_m}) begin
              sgn_d = sa;
              exp_d = $signed({3'd0, a_e});
              m_d   = {1'b0, a_m, 54'd0};
              sm_d  = {1'b0, b_m, 54'd0};
              dif_d = a_e - b_e;
            end else begin
              sgn_d = sb;
              exp_d = $signed({3'd0, b_e});
              m_d   = {1'b0, b_m, 54'd0};
              sm_d  = {1'b0, a_m, 54'd0};
              dif_d = b_e - a_e;
            end
            st_d = FS_ALIGN;
          end
        end
      end
      FS_MUL: begin
        m_d   = m_q + ({54'd0, pp} << pp_sh);
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          st_d = FS_NORM;
        end
      end
      FS_ALIGN: begin
        if (dif_q >= 11'(MW)) begin
          sm_d = {{(MW-1){1'b0}}, |sm_q};
        end else begin
          sm_d = (sm_q >> dif_q[6:0])
               | {{(MW-1){1'b0}}, |(sm_q & ~(ones << dif_q[6:0]))};
        end
        st_d = FS_ADD;
      end
      FS_ADD: begin
        m_d = sum;
        if (sub_q && (sum == '0)) begin
          sgn_d = 1'b0;
        end
        st_d = FS_NORM;
      end
      FS_NORM: begin
        if ((m_q == '0) && !stk_q) begin
          res_d  = {sgn_q, 63'd0};
          done_d = 1'b1;
          st_d   = FS_IDLE;
        end else if (m_q[MW-1]) begin
          m_d   = m_q >> 1;
          stk_d = stk_q | m_q[0];
          exp_d = exp_q + 14'sd1;
        end else if (!m_q[MW-2]) begin
          if (m_q[MW-2:MW-17] == 16'd0) begin
            m_d   = m_q << 16;
            exp_d = exp_q - 14'sd16;
          end else begin
            m_d   = m_q << 1;
            exp_d = exp_q - 14'sd1;
          end
        end else if (exp_q < 14'sd1) begin
          st_d = FS_DENORM;
        end else begin
          st_d = FS_ROUND;
        end
      end
      FS_DENORM: begin
        if (amt >= 14'(MW)) begin
          m_d   = '0;
          stk_d = stk_q | (|m_q);
        end else begin
          m_d   = m_q >> amt[6:0];
          stk_d = stk_q | (|(m_q & ~(ones << amt[6:0])));
        end
        exp_d = 14'sd1;
        st_d  = FS_ROUND;
      end
      FS_ROUND: begin
        if (exp_r >= 14'sd2047) begin
          res_d = {sgn_q, 11'h7FF, 52'd0};
        end else if (rnd2[53]) begin
          res_d = {sgn_q, exp_r[10:0], 52'd0};
        end else begin
          res_d = {sgn_q, rnd2[52] ? exp_q[10:0] : 11'd0, rnd2[51:0]};
        end
        done_d = 1'b1;
        st_d   = FS_IDLE;
      end
      default: st_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= FS_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sgn_q <= sgn_d;
    exp_q <= exp_d;
    m_q   <= m_d;
    sm_q  <= sm_d;
    stk_q <= stk_d;
    sub_q <= sub_d;
    dif_q <= dif_d;
    cnt_q <= cnt_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// File: sim/tb_clamped_recurrent_matrix_power.sv
// Testbench for clamped_recurrent_matrix_power: loads the matrix and start vector,
// runs the chain at several step counts and checks every emitted element.
// Depends on crmp_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_clamped_recurrent_matrix_power;
  import crmp_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int IDLE_LIMIT = 1000000;
  localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MIN_DENORM = 64'h0000_0000_0000_0001;
  localparam logic [63:0] MAX_NORMAL = 64'h7FEF_FFFF_FFFF_FFFF;

  class power_scoreboard;
    real mat [DIM*DIM];
    real vec [DIM];
    real chain [MAX_STEPS][DIM];
    int unsigned step_count = 100;
    out_item_t element_q [$];
    int errors = 0;

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void compute_run();
      real r [DIM];
      real acc, s;
      int steps;
      out_item_t e;
      steps = (step_count > MAX_STEPS) ? MAX_STEPS : step_count;
      if (steps == 0) begin
        for (int i = 0; i < DIM; i++) r[i] = vec[i];
      end else begin
        for (int k = 0; k < steps; k++) begin
          for (int i = 0; i < DIM; i++) begin
            acc = 0.0;
            for (int j = 0; j < DIM; j++)
              acc = acc + mat[i*DIM+j] * ((k == 0) ? vec[j] : chain[k-1][j]);
            chain[k][i] = acc;
          end
        end
        for (int i = 0; i < DIM; i++) r[i] = chain[steps-1][i];
        for (int k = steps - 1; k >= 0; k--) begin
          for (int i = 0; i < DIM; i++) begin
            s = r[i] + chain[k][i];
            if (s < 0.0) s = 0.0;
            if (s > 20.0) s = 20.0;
            r[i] = s;
          end
        end
      end
      for (int i = 0; i < DIM; i++) begin
        e.element_index = 3'(i);
        e.element_value = $realtobits(r[i]);
        e.last = (i == DIM - 1);
        element_q.push_back(e);
      end
    endfunction

    function void note_input(in_item_t it);
      case (it.func)
        FUNC_MAT: if (it.row < DIM && it.col < DIM)
          mat[it.row*DIM+it.col] = $bitstoreal(it.value);
        FUNC_VEC: if (it.row < DIM) vec[it.row] = $bitstoreal(it.value);
        FUNC_RUN: compute_run();
        default: ;
      endcase
    endfunction

    function bit is_nan(logic [63:0] b);
      return (b[62:52] == 11'h7FF) && (b[51:0] != 0);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (element_q.size() == 0) begin
        report($sformatf("unexpected element idx=%0d val=%h", got.element_index,
                         got.element_value));
        return;
      end
      want = element_q.pop_front();
      if (got.element_index !== want.element_index)
        report($sformatf("index got %0d want %0d", got.element_index, want.element_index));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b idx %0d", got.last, want.last,
                         want.element_index));
      if (is_nan(want.element_value) ? !is_nan(got.element_value)
                                     : (got.element_value !== want.element_value))
        report($sformatf("value idx %0d got %h want %h", want.element_index,
                         got.element_value, want.element_value));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;

  power_scoreboard sb = new();
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int idle_cycles = 0;

  clamped_recurrent_matrix_power dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // sampled mid-cycle; a transaction completes at the following rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_clamped_recurrent_matrix_power NOT OK");
        $finish;
      end
    end
  end

  task send_item(in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(negedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    sb.note_input(it);
    @(posedge clk_i);
  endtask

  task send(logic [1:0] f, int r, int c, logic [63:0] v);
    in_item_t it;
    it.func = f;
    it.row = 3'(r);
    it.col = 3'(c);
    it.value = v;
    send_item(it);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.element_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_steps(int v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CFG_W'(v);
    @(negedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    sb.step_count = v;
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function logic [63:0] rand_double();
    logic [63:0] specials [6];
    specials = '{POS_INF, POS_INF | NEG_ZERO, NEG_ZERO, MIN_DENORM, MAX_NORMAL,
                 DEFAULT_NAN};
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return specials[$urandom_range(5)];
      2: return $realtobits((real'($urandom_range(4000)) - 2000.0) / 1000.0);
      default: return $realtobits((real'($urandom_range(2000)) - 1000.0) / 2500.0);
    endcase
  endfunction

  task fill_all(logic [63:0] v);
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) send(FUNC_MAT, i, j, v ^ 64'(i*DIM+j));
      send(FUNC_VEC, i, 0, v);
    end
  endtask

  task random_phase(int steps, int n, int max_runs);
    in_item_t it;
    int runs;
    runs = 0;
    write_steps(steps);
    for (int k = 0; k < n; k++) begin
      it.row = 3'($urandom_range(DIM - 1));
      it.col = 3'($urandom_range(DIM - 1));
      it.value = rand_double();
      case ($urandom_range(15))
        0, 1: it.func = FUNC_RUN;
        2: it.func = FUNC_NONE;
        3: begin
          it.func = FUNC_MAT;
          it.row = 3'($urandom);
          it.col = 3'($urandom);
        end
        4, 5, 6: it.func = FUNC_VEC;
        default: it.func = FUNC_MAT;
      endcase
      if (it.func == FUNC_RUN) begin
        if (runs >= max_runs) it.func = FUNC_MAT;
        else runs++;
      end
      send_item(it);
    end
    send(FUNC_RUN, $urandom, $urandom, {$urandom, $urandom});
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full load before any run, then one run at the reset step count
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++)
        send(FUNC_MAT, i, j, $realtobits((i == j) ? 0.5 : 0.05));
      send(FUNC_VEC, i, 0, $realtobits(1.0 + i));
    end
    send(FUNC_RUN, 0, 0, '0);

    write_steps(0);
    send(FUNC_VEC, 0, 7, 64'hFFFF_FFFF_FFFF_FFFF);
    send(FUNC_VEC, 1, 0, NEG_ZERO);
    send(FUNC_VEC, 2, 0, POS_INF);
    send(FUNC_VEC, 3, 0, MIN_DENORM);
    send(FUNC_VEC, 4, 0, MAX_NORMAL);
    send(FUNC_VEC, 5, 0, 64'h0);
    send(FUNC_MAT, 7, 0, 64'h0);
    send(FUNC_MAT, 0, 5, 64'h0);
    send(FUNC_NONE, 0, 0, 64'h0);
    send(FUNC_RUN, 7, 7, 64'hFFFF_FFFF_FFFF_FFFF);

    write_steps(2);
    send(FUNC_RUN, 0, 0, '0);
    send(FUNC_VEC, 0, 0, $realtobits(-3.0));
    send(FUNC_VEC, 2, 0, $realtobits(25.0));
    send(FUNC_MAT, 1, 1, NEG_ZERO);
    send(FUNC_RUN, 0, 0, '0);
    fill_all($realtobits(-0.25));
    send(FUNC_RUN, 0, 0, '0);

    write_steps(255);
    fill_all($realtobits(0.1));
    send(FUNC_RUN, 0, 0, '0);

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 67; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 67; end
        default: begin in_idle_pct = 38; out_stall_pct = 38; end
      endcase
      case (p)
        0: random_phase(1, 12, 8);
        1: random_phase(3, 12, 8);
        2: random_phase(0, 12, 8);
        3: random_phase(2, 12, 8);
        4: random_phase(128, 20, 0);
        5: random_phase(5, 12, 8);
        6: random_phase(129, 10, 0);
        default: random_phase($urandom_range(1, 4), 12, 8);
      endcase
    end

    drain();
    if (sb.errors == 0 && sb.element_q.size() == 0)
      $display("tb_clamped_recurrent_matrix_power OK");
    else
      $display("tb_clamped_recurrent_matrix_power NOT OK");
    $finish;
  end

endmodule

// File: files.f
rtl/crmp_pkg.sv
rtl/crmp_fpu.sv
rtl/clamped_recurrent_matrix_power.sv
sim/tb_clamped_recurrent_matrix_power.sv
